### src/tile_dirty_map_top_assert.svh
// assertion macros shared by the tile dirty map modules
// no dependencies; taken in by `include where assertions are written
`ifndef TILE_DIRTY_MAP_TOP_ASSERT_SVH
`define TILE_DIRTY_MAP_TOP_ASSERT_SVH

// same-cycle implication, checked outside reset
`define TDM_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define TDM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/tdm_pkg.sv
// shared types and constants of the tile dirty map
// no dependencies; used by every module of the block
package tdm_pkg;

    localparam int unsigned DEPTH     = 32;
    localparam int unsigned ROW_W     = 32;
    localparam int unsigned ROW_IDX_W = 5;
    localparam int unsigned PIX_W     = 12;
    localparam int unsigned DIM_W     = 6;
    localparam int unsigned POS_W     = 9;

    // reciprocal division of pixel positions by the tile size
    localparam int unsigned OPND_W    = 13;
    localparam int unsigned DIV_SHIFT = 20;
    localparam int unsigned RECIP_W   = 20;

    // operation codes
    localparam logic [1:0] OP_MARK    = 2'd0;
    localparam logic [1:0] OP_MERGE   = 2'd1;
    localparam logic [1:0] OP_RESTORE = 2'd2;
    localparam logic [1:0] OP_CLEAR   = 2'd3;

    // configuration register indexes
    localparam logic CFG_MAP_COLUMNS = 1'b0;
    localparam logic CFG_MAP_ROWS    = 1'b1;

    localparam logic [DIM_W-1:0] COLUMNS_RESET = 6'd20;
    localparam logic [DIM_W-1:0] ROWS_RESET    = 6'd12;

    // division steps of a mark request
    localparam logic [1:0] DIV_X1 = 2'd0;
    localparam logic [1:0] DIV_X2 = 2'd1;
    localparam logic [1:0] DIV_Y1 = 2'd2;
    localparam logic [1:0] DIV_Y2 = 2'd3;

    typedef struct packed {
        logic [1:0]           op;
        logic [PIX_W-1:0]     rect_x;
        logic [PIX_W-1:0]     rect_y;
        logic [PIX_W-1:0]     rect_w;
        logic [PIX_W-1:0]     rect_h;
        logic [ROW_IDX_W-1:0] row_index;
        logic [ROW_W-1:0]     row_bits;
    } item_t;

    typedef struct packed {
        logic             tile_valid;
        logic [POS_W-1:0] tile_x;
        logic [POS_W-1:0] tile_y;
        logic             last;
    } result_t;

    typedef enum logic [2:0] {
        CS_IDLE,
        CS_DISPATCH,
        CS_DIV,
        CS_SETUP,
        CS_READ,
        CS_WRITE,
        CS_EMIT,
        CS_RESP
    } ctrl_state_t;

    typedef struct packed {
        logic       capture;
        logic       div_step;
        logic [1:0] div_sel;
        logic       mark_setup;
        logic       mem_rd;
        logic       mem_wr;
        logic       row_inc;
        logic       clear_all;
        logic       emit_tile;
        logic       emit_resp;
    } ctrl_cmd_t;

    typedef struct packed {
        logic [1:0] op;
        logic       row_ok;
        logic       mark_ok;
        logic       row_done;
        logic       restore_nonzero;
        logic       word_nonzero;
        logic       tile_last;
        logic       slot_free;
    } ctrl_status_t;

endpackage

### src/tdm_row_mem.sv
// row word store of the tile dirty map, one word per tile row
// depends on tdm_pkg; rows read as zero until written since the last clear
module tdm_row_mem
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           rd_en,
    input  logic                           wr_en,
    input  logic                           clear,
    input  logic [tdm_pkg::ROW_IDX_W-1:0]  addr,
    input  logic [tdm_pkg::ROW_W-1:0]      wr_data,
    output logic [tdm_pkg::ROW_W-1:0]      rd_data
);

    logic [tdm_pkg::ROW_W-1:0] row_store_reg [tdm_pkg::DEPTH];
    logic [tdm_pkg::DEPTH-1:0] valid_reg;
    logic [tdm_pkg::ROW_W-1:0] rd_data_reg;

    // per-row valid bits, cleared at once by reset or clear
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (clear)
        begin
            valid_reg <= '0;
        end
        else if (wr_en)
        begin
            valid_reg[addr] <= 1'b1;
        end
    end

    // word storage with registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            row_store_reg[addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= valid_reg[addr] ? row_store_reg[addr] : '0;
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### src/tdm_datapath.sv
// datapath of the tile dirty map: config registers, tile span division,
// mark masks, restore scan and the result register; depends on tdm_pkg
module tdm_datapath #(
    parameter int unsigned TILE_W   = 16,
    parameter int unsigned TILE_H   = 16,
    parameter int unsigned MAX_COLS = 32,
    parameter int unsigned MAX_ROWS = 32
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  tdm_pkg::item_t                 item,
    input  tdm_pkg::ctrl_cmd_t             cmd,
    output tdm_pkg::ctrl_status_t          status,
    input  logic                           cfg_valid,
    input  logic                           cfg_index,
    input  logic [tdm_pkg::DIM_W-1:0]      cfg_data,
    output logic [tdm_pkg::ROW_IDX_W-1:0]  mem_addr,
    output logic [tdm_pkg::ROW_W-1:0]      mem_wr_data,
    input  logic [tdm_pkg::ROW_W-1:0]      mem_rd_data,
    output tdm_pkg::result_t               result,
    output logic                           result_valid,
    input  logic                           result_ready
);

    localparam int unsigned COL_CAP = (MAX_COLS < 32) ? MAX_COLS : 32;
    localparam int unsigned ROW_CAP = (MAX_ROWS < 32) ? MAX_ROWS : 32;
    localparam int unsigned RECIP_X =
        ((1 << tdm_pkg::DIV_SHIFT) + TILE_W - 1) / TILE_W;
    localparam int unsigned RECIP_Y =
        ((1 << tdm_pkg::DIV_SHIFT) + TILE_H - 1) / TILE_H;
    localparam int unsigned PROD_W  = tdm_pkg::OPND_W + tdm_pkg::RECIP_W;
    localparam int unsigned XP_RAW  = tdm_pkg::ROW_IDX_W + $clog2(TILE_W + 1);
    localparam int unsigned YP_RAW  = tdm_pkg::ROW_IDX_W + $clog2(TILE_H + 1);
    localparam int unsigned XP_W    = (XP_RAW > tdm_pkg::POS_W) ? XP_RAW : tdm_pkg::POS_W;
    localparam int unsigned YP_W    = (YP_RAW > tdm_pkg::POS_W) ? YP_RAW : tdm_pkg::POS_W;

    logic [tdm_pkg::DIM_W-1:0]     map_columns_reg;
    logic [tdm_pkg::DIM_W-1:0]     map_rows_reg;
    logic [tdm_pkg::DIM_W-1:0]     cols;
    logic [tdm_pkg::DIM_W-1:0]     rows;
    logic [tdm_pkg::DIM_W-1:0]     cols_m1;
    logic [tdm_pkg::DIM_W-1:0]     rows_m1;
    logic [tdm_pkg::ROW_W-1:0]     colmask;

    tdm_pkg::item_t                item_reg;

    logic [tdm_pkg::OPND_W-1:0]    div_opnd;
    logic [tdm_pkg::RECIP_W-1:0]   div_recip;
    logic [PROD_W-1:0]             div_prod;
    logic [tdm_pkg::PIX_W-1:0]     div_quot;
    logic [tdm_pkg::PIX_W-1:0]     x1_reg;
    logic [tdm_pkg::PIX_W-1:0]     x2_reg;
    logic [tdm_pkg::PIX_W-1:0]     y1_reg;
    logic [tdm_pkg::PIX_W-1:0]     y2_reg;

    logic                          span_ok;
    logic [tdm_pkg::ROW_IDX_W-1:0] x2_clip;
    logic [tdm_pkg::ROW_IDX_W-1:0] y2_clip;
    logic [tdm_pkg::ROW_W-1:0]     mark_mask;
    logic [tdm_pkg::ROW_W-1:0]     mask_reg;
    logic [tdm_pkg::ROW_IDX_W-1:0] row_reg;
    logic [tdm_pkg::ROW_IDX_W-1:0] row_end_reg;

    logic [tdm_pkg::ROW_W-1:0]     restore_word;
    logic [tdm_pkg::ROW_W-1:0]     word_reg;
    logic [tdm_pkg::ROW_IDX_W-1:0] top_idx;
    logic [tdm_pkg::ROW_W-1:0]     word_cleared;
    logic [XP_W-1:0]               tile_x_full;
    logic [YP_W-1:0]               tile_y_full;

    tdm_pkg::result_t              res_reg;
    logic                          res_valid_reg;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            map_columns_reg <= tdm_pkg::COLUMNS_RESET;
            map_rows_reg    <= tdm_pkg::ROWS_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                tdm_pkg::CFG_MAP_COLUMNS: map_columns_reg <= cfg_data;
                tdm_pkg::CFG_MAP_ROWS:    map_rows_reg    <= cfg_data;
                default: ;
            endcase
        end
    end

    // columns and rows in use: zero counts as one, capped at the map size
    always_comb
    begin
        cols = (map_columns_reg == '0) ? 6'd1 : map_columns_reg;
        if (cols > 6'(COL_CAP))
        begin
            cols = 6'(COL_CAP);
        end
        rows = (map_rows_reg == '0) ? 6'd1 : map_rows_reg;
        if (rows > 6'(ROW_CAP))
        begin
            rows = 6'(ROW_CAP);
        end
        cols_m1 = cols - 6'd1;
        rows_m1 = rows - 6'd1;
        for (int i = 0; i < tdm_pkg::ROW_W; i++)
        begin
            colmask[i] = (6'(i) < cols);
        end
    end

    // request capture
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            item_reg <= item;
        end
    end

    // tile index by reciprocal multiply, one edge per step
    always_comb
    begin
        case (cmd.div_sel)
            tdm_pkg::DIV_X1:
            begin
                div_opnd  = {1'b0, item_reg.rect_x};
                div_recip = tdm_pkg::RECIP_W'(RECIP_X);
            end
            tdm_pkg::DIV_X2:
            begin
                div_opnd  = {1'b0, item_reg.rect_x} + {1'b0, item_reg.rect_w} - 13'd1;
                div_recip = tdm_pkg::RECIP_W'(RECIP_X);
            end
            tdm_pkg::DIV_Y1:
            begin
                div_opnd  = {1'b0, item_reg.rect_y};
                div_recip = tdm_pkg::RECIP_W'(RECIP_Y);
            end
            default:
            begin
                div_opnd  = {1'b0, item_reg.rect_y} + {1'b0, item_reg.rect_h} - 13'd1;
                div_recip = tdm_pkg::RECIP_W'(RECIP_Y);
            end
        endcase
        div_prod = PROD_W'(div_opnd) * PROD_W'(div_recip);
        div_quot = div_prod[tdm_pkg::DIV_SHIFT +: tdm_pkg::PIX_W];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.div_step)
        begin
            case (cmd.div_sel)
                tdm_pkg::DIV_X1: x1_reg <= div_quot;
                tdm_pkg::DIV_X2: x2_reg <= div_quot;
                tdm_pkg::DIV_Y1: y1_reg <= div_quot;
                default:         y2_reg <= div_quot;
            endcase
        end
    end

    // clipped span and column mask of a mark
    always_comb
    begin
        span_ok = (item_reg.rect_w != '0) && (item_reg.rect_h != '0)
                  && (x1_reg < {6'd0, cols}) && (y1_reg < {6'd0, rows});
        x2_clip = (x2_reg >= {6'd0, cols}) ? cols_m1[4:0] : x2_reg[4:0];
        y2_clip = (y2_reg >= {6'd0, rows}) ? rows_m1[4:0] : y2_reg[4:0];
        for (int i = 0; i < tdm_pkg::ROW_W; i++)
        begin
            mark_mask[i] = (12'(i) >= x1_reg) && (5'(i) <= x2_clip);
        end
    end

    // mark row walk
    always_ff @(posedge clk)
    begin
        if (cmd.mark_setup)
        begin
            mask_reg    <= mark_mask;
            row_reg     <= y1_reg[4:0];
            row_end_reg <= y2_clip;
        end
        else if (cmd.row_inc)
        begin
            row_reg <= row_reg + 5'd1;
        end
    end

    // row address and read-modify-write data
    always_comb
    begin
        mem_addr     = (item_reg.op == tdm_pkg::OP_MARK) ? row_reg : item_reg.row_index;
        restore_word = mem_rd_data & colmask;
        case (item_reg.op)
            tdm_pkg::OP_MARK:  mem_wr_data = mem_rd_data | mask_reg;
            tdm_pkg::OP_MERGE: mem_wr_data = mem_rd_data | (item_reg.row_bits & colmask);
            default:           mem_wr_data = mem_rd_data & ~colmask;
        endcase
    end

    // restore scan, highest dirty column first
    always_comb
    begin
        top_idx = '0;
        for (int i = 0; i < tdm_pkg::ROW_W; i++)
        begin
            if (word_reg[i])
            begin
                top_idx = 5'(i);
            end
        end
        word_cleared          = word_reg;
        word_cleared[top_idx] = 1'b0;
        tile_x_full = XP_W'(top_idx) * XP_W'(TILE_W);
        tile_y_full = YP_W'(item_reg.row_index) * YP_W'(TILE_H);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mem_wr)
        begin
            word_reg <= restore_word;
        end
        else if (cmd.emit_tile)
        begin
            word_reg <= word_cleared;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (cmd.emit_tile || cmd.emit_resp)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (result_ready)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit_tile)
        begin
            res_reg.tile_valid <= 1'b1;
            res_reg.tile_x     <= tile_x_full[tdm_pkg::POS_W-1:0];
            res_reg.tile_y     <= tile_y_full[tdm_pkg::POS_W-1:0];
            res_reg.last       <= (word_cleared == '0);
        end
        else if (cmd.emit_resp)
        begin
            res_reg.tile_valid <= 1'b0;
            res_reg.tile_x     <= '0;
            res_reg.tile_y     <= '0;
            res_reg.last       <= 1'b1;
        end
    end

    assign result       = res_reg;
    assign result_valid = res_valid_reg;

    // status to the controller
    always_comb
    begin
        status.op              = item_reg.op;
        status.row_ok          = ({1'b0, item_reg.row_index} < rows);
        status.mark_ok         = span_ok;
        status.row_done        = (row_reg == row_end_reg);
        status.restore_nonzero = (restore_word != '0);
        status.word_nonzero    = (word_reg != '0);
        status.tile_last       = (word_cleared == '0);
        status.slot_free       = !res_valid_reg || result_ready;
    end

endmodule

### src/tdm_ctrl.sv
// controller of the tile dirty map: sequences each request through the datapath
// depends on tdm_pkg and tile_dirty_map_top_assert.svh
`include "tile_dirty_map_top_assert.svh"

module tdm_ctrl
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  item_valid,
    output logic                  item_ready,
    input  tdm_pkg::ctrl_status_t status,
    output tdm_pkg::ctrl_cmd_t    cmd
);

    tdm_pkg::ctrl_state_t state_reg;
    tdm_pkg::ctrl_state_t state_next;
    logic [1:0]           div_cnt_reg;
    logic [1:0]           div_cnt_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= tdm_pkg::CS_IDLE;
            div_cnt_reg <= tdm_pkg::DIV_X1;
        end
        else
        begin
            state_reg   <= state_next;
            div_cnt_reg <= div_cnt_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next   = state_reg;
        div_cnt_next = div_cnt_reg;
        cmd          = '0;
        cmd.div_sel  = div_cnt_reg;
        item_ready   = 1'b0;
        case (state_reg)
            tdm_pkg::CS_IDLE:
            begin
                item_ready = 1'b1;
                if (item_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = tdm_pkg::CS_DISPATCH;
                end
            end
            tdm_pkg::CS_DISPATCH:
            begin
                case (status.op)
                    tdm_pkg::OP_MARK:
                    begin
                        div_cnt_next = tdm_pkg::DIV_X1;
                        state_next   = tdm_pkg::CS_DIV;
                    end
                    tdm_pkg::OP_MERGE, tdm_pkg::OP_RESTORE:
                    begin
                        state_next = status.row_ok ? tdm_pkg::CS_READ : tdm_pkg::CS_RESP;
                    end
                    tdm_pkg::OP_CLEAR:
                    begin
                        cmd.clear_all = 1'b1;
                        state_next    = tdm_pkg::CS_RESP;
                    end
                    default:
                    begin
                        state_next = tdm_pkg::CS_RESP;
                    end
                endcase
            end
            tdm_pkg::CS_DIV:
            begin
                cmd.div_step = 1'b1;
                div_cnt_next = div_cnt_reg + 2'd1;
                if (div_cnt_reg == tdm_pkg::DIV_Y2)
                begin
                    state_next = tdm_pkg::CS_SETUP;
                end
            end
            tdm_pkg::CS_SETUP:
            begin
                if (status.mark_ok)
                begin
                    cmd.mark_setup = 1'b1;
                    state_next     = tdm_pkg::CS_READ;
                end
                else
                begin
                    state_next = tdm_pkg::CS_RESP;
                end
            end
            tdm_pkg::CS_READ:
            begin
                cmd.mem_rd = 1'b1;
                state_next = tdm_pkg::CS_WRITE;
            end
            tdm_pkg::CS_WRITE:
            begin
                cmd.mem_wr = 1'b1;
                case (status.op)
                    tdm_pkg::OP_MARK:
                    begin
                        if (status.row_done)
                        begin
                            state_next = tdm_pkg::CS_RESP;
                        end
                        else
                        begin
                            cmd.row_inc = 1'b1;
                            state_next  = tdm_pkg::CS_READ;
                        end
                    end
                    tdm_pkg::OP_RESTORE:
                    begin
                        state_next = status.restore_nonzero ? tdm_pkg::CS_EMIT
                                                            : tdm_pkg::CS_RESP;
                    end
                    default:
                    begin
                        state_next = tdm_pkg::CS_RESP;
                    end
                endcase
            end
            tdm_pkg::CS_EMIT:
            begin
                if (status.slot_free)
                begin
                    cmd.emit_tile = 1'b1;
                    if (status.tile_last)
                    begin
                        state_next = tdm_pkg::CS_IDLE;
                    end
                end
            end
            tdm_pkg::CS_RESP:
            begin
                if (status.slot_free)
                begin
                    cmd.emit_resp = 1'b1;
                    state_next    = tdm_pkg::CS_IDLE;
                end
            end
            default:
            begin
                state_next = tdm_pkg::CS_IDLE;
            end
        endcase
    end

    // an accepted request is always decoded next
    `TDM_ASSERT_NEXT(a_accept_dispatch, clk, rst_n, item_valid && item_ready,
        state_reg == tdm_pkg::CS_DISPATCH, "accepted request not dispatched")

    // the restore scan only runs with dirty tiles left
    `TDM_ASSERT_IMPL(a_emit_has_tiles, clk, rst_n, state_reg == tdm_pkg::CS_EMIT,
        status.word_nonzero, "restore scan with empty word")

    // the last tile of a restore ends the request
    `TDM_ASSERT_NEXT(a_last_tile_idle, clk, rst_n, cmd.emit_tile && status.tile_last,
        state_reg == tdm_pkg::CS_IDLE, "restore continues past last tile")

endmodule

### src/tile_dirty_map_top.sv
// Tile dirty map: one dirty bit per screen tile, one 32-bit word per tile row.
// Requests come in on item_valid/item_ready with an item_t payload: mark a
// pixel rectangle, merge a row word, restore a row, or clear the whole map.
// Results leave on result_valid/result_ready as result_t; every request gives
// at least one result, the final one with last set. Restore clears the row's
// bits in use, then gives one result per dirty tile, rightmost first.
// Configuration writes on cfg_valid/cfg_ready (always ready) set the columns
// (index 0) and rows (index 1) in use; write them only while the block is idle.
// Rows are updated read-modify-write, read then write, through a single-port
// row store; tile spans use one reciprocal multiplier, one step a cycle.
// One request is in work at a time; the next is accepted from the cycle after
// the final result enters the output register, even if it is not taken.
// A stalled receiver holds the result register and pauses restore output.
// Reset empties the map at once and loads 20 columns and 12 rows.
// Depends on tdm_pkg, tdm_ctrl, tdm_datapath and tdm_row_mem.
module tile_dirty_map_top #(
    parameter int unsigned TILE_W   = 16,
    parameter int unsigned TILE_H   = 16,
    parameter int unsigned MAX_COLS = 32,
    parameter int unsigned MAX_ROWS = 32
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       item_valid,
    output logic                       item_ready,
    input  tdm_pkg::item_t             item,
    output logic                       result_valid,
    input  logic                       result_ready,
    output tdm_pkg::result_t           result,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic                       cfg_index,
    input  logic [tdm_pkg::DIM_W-1:0]  cfg_data
);

    tdm_pkg::ctrl_cmd_t            cmd;
    tdm_pkg::ctrl_status_t         status;
    logic [tdm_pkg::ROW_IDX_W-1:0] mem_addr;
    logic [tdm_pkg::ROW_W-1:0]     mem_wr_data;
    logic [tdm_pkg::ROW_W-1:0]     mem_rd_data;

    // configuration writes are taken in any cycle
    assign cfg_ready = 1'b1;

    // request sequencer
    tdm_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .status     (status),
        .cmd        (cmd)
    );

    // arithmetic, masks and result register
    tdm_datapath #(
        .TILE_W   (TILE_W),
        .TILE_H   (TILE_H),
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .item         (item),
        .cmd          (cmd),
        .status       (status),
        .cfg_valid    (cfg_valid),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .mem_addr     (mem_addr),
        .mem_wr_data  (mem_wr_data),
        .mem_rd_data  (mem_rd_data),
        .result       (result),
        .result_valid (result_valid),
        .result_ready (result_ready)
    );

    // dirty row store
    tdm_row_mem u_row_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (cmd.mem_rd),
        .wr_en   (cmd.mem_wr),
        .clear   (cmd.clear_all),
        .addr    (mem_addr),
        .wr_data (mem_wr_data),
        .rd_data (mem_rd_data)
    );

endmodule

### verif/tb.sv
// self-checking testbench of tile_dirty_map_top: a directed table, then random requests
// results are predicted from a private copy of the map; depends on tdm_pkg and the block
module tb;

    localparam int unsigned TILE_PX_W    = 16;
    localparam int unsigned TILE_PX_H    = 16;
    localparam int unsigned COLS_LIMIT   = 32;
    localparam int unsigned ROWS_LIMIT   = 32;
    localparam int unsigned DRAIN_CYCLES = 100;
    localparam int unsigned HOLD_CYCLES  = 400;

    localparam tdm_pkg::result_t NO_TILE =
        '{tile_valid: 1'b0, tile_x: '0, tile_y: '0, last: 1'b1};

    typedef struct {
        tdm_pkg::item_t   req;
        bit               typed;
        tdm_pkg::result_t want;
    } plan_row_t;

    logic                      clk          = 1'b0;
    logic                      rst_n        = 1'b0;
    logic                      item_valid   = 1'b0;
    logic                      item_ready;
    tdm_pkg::item_t            item         = '0;
    logic                      result_valid;
    logic                      result_ready = 1'b0;
    tdm_pkg::result_t          result;
    logic                      cfg_valid    = 1'b0;
    logic                      cfg_ready;
    logic                      cfg_index    = tdm_pkg::CFG_MAP_COLUMNS;
    logic [tdm_pkg::DIM_W-1:0] cfg_data     = '0;

    // private copy of the map and its registers
    logic [tdm_pkg::ROW_W-1:0] dirty_words [tdm_pkg::DEPTH];
    logic [tdm_pkg::DIM_W-1:0] columns_reg;
    logic [tdm_pkg::DIM_W-1:0] rows_reg;

    tdm_pkg::result_t awaited_results [$];
    plan_row_t        opening_plan [$];
    int unsigned      mismatch_count    = 0;
    int unsigned      sender_idle_pct   = 0;
    int unsigned      receiver_idle_pct = 0;
    bit               hold_request      = 1'b0;
    bit               hold_finished     = 1'b0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    tile_dirty_map_top #(
        .TILE_W   (TILE_PX_W),
        .TILE_H   (TILE_PX_H),
        .MAX_COLS (COLS_LIMIT),
        .MAX_ROWS (ROWS_LIMIT)
    ) DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    // columns or rows actually in use: zero counts as one, capped at the map size
    function automatic int unsigned usable(input logic [tdm_pkg::DIM_W-1:0] v);
        int unsigned n;
        n = v;
        if (n == 0)
            n = 1;
        if (n > 32)
            n = 32;
        return n;
    endfunction

    function automatic logic [tdm_pkg::ROW_W-1:0] bits_through(input int unsigned n);
        if (n >= 31)
            return '1;
        return (32'd1 << (n + 1)) - 32'd1;
    endfunction

    // update the map for one request and list the results it gives
    task automatic apply_request(input tdm_pkg::item_t req, ref tdm_pkg::result_t outs[$]);
        int unsigned               cols;
        int unsigned               rows;
        int unsigned               x1;
        int unsigned               x2;
        int unsigned               y1;
        int unsigned               y2;
        logic [tdm_pkg::ROW_W-1:0] colmask;
        logic [tdm_pkg::ROW_W-1:0] span;
        logic [tdm_pkg::ROW_W-1:0] word;
        tdm_pkg::result_t          tile;
        cols    = usable(columns_reg);
        rows    = usable(rows_reg);
        colmask = bits_through(cols - 1);
        outs.delete();
        case (req.op)
            tdm_pkg::OP_MARK:
            begin
                if (req.rect_w != 0 && req.rect_h != 0)
                begin
                    x1 = req.rect_x;
                    x2 = (x1 + req.rect_w - 1) / TILE_PX_W;
                    x1 = x1 / TILE_PX_W;
                    y1 = req.rect_y;
                    y2 = (y1 + req.rect_h - 1) / TILE_PX_H;
                    y1 = y1 / TILE_PX_H;
                    // a span starting past the map marks nothing, otherwise clip it
                    if (x1 < cols && y1 < rows)
                    begin
                        if (x2 >= cols)
                            x2 = cols - 1;
                        if (y2 >= rows)
                            y2 = rows - 1;
                        span = bits_through(x2) & ~((32'd1 << x1) - 32'd1);
                        for (int unsigned i = y1; i <= y2; i++)
                            dirty_words[i] |= span;
                    end
                end
            end
            tdm_pkg::OP_MERGE:
            begin
                if (req.row_index < rows)
                    dirty_words[req.row_index] |= req.row_bits & colmask;
            end
            tdm_pkg::OP_CLEAR:
            begin
                foreach (dirty_words[i])
                    dirty_words[i] = '0;
            end
            default:
            begin
                // restore: rightmost tile first, last flag on the final dirty one
                if (req.row_index < rows)
                begin
                    word = dirty_words[req.row_index] & colmask;
                    for (int c = int'(cols) - 1; c >= 0; c--)
                    begin
                        if (word[c])
                        begin
                            word[c]         = 1'b0;
                            tile.tile_valid = 1'b1;
                            tile.tile_x     = tdm_pkg::POS_W'(c * TILE_PX_W);
                            tile.tile_y     = tdm_pkg::POS_W'(req.row_index * TILE_PX_H);
                            tile.last       = (word == '0);
                            outs.push_back(tile);
                        end
                    end
                    dirty_words[req.row_index] &= ~colmask;
                end
            end
        endcase
        if (outs.size() == 0)
            outs.push_back(NO_TILE);
    endtask

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        $display("mismatch at %0t: %s", $time, msg);
    endtask

    // offer one request, hold it until taken, then record what it should give
    task automatic send_request(input tdm_pkg::item_t req, input bit typed,
                                input tdm_pkg::result_t want);
        tdm_pkg::result_t predicted [$];
        item_valid <= 1'b1;
        item       <= req;
        @(posedge clk);
        while (!item_ready)
            @(posedge clk);
        apply_request(req, predicted);
        if (typed)
            awaited_results.push_back(want);
        else
            foreach (predicted[k])
                awaited_results.push_back(predicted[k]);
        while ($urandom_range(0, 99) < sender_idle_pct)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
    endtask

    task automatic wait_idle();
        item_valid <= 1'b0;
        while (awaited_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // both registers, back to back on the write channel
    task automatic resize_map(input logic [tdm_pkg::DIM_W-1:0] cols,
                              input logic [tdm_pkg::DIM_W-1:0] rows);
        cfg_valid <= 1'b1;
        cfg_index <= tdm_pkg::CFG_MAP_COLUMNS;
        cfg_data  <= cols;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        columns_reg = cols;
        cfg_index <= tdm_pkg::CFG_MAP_ROWS;
        cfg_data  <= rows;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        rows_reg = rows;
        cfg_valid <= 1'b0;
    endtask

    // mostly in-map rectangles and in-range rows, some raw noise
    function automatic tdm_pkg::item_t random_request();
        tdm_pkg::item_t req;
        int unsigned    cols;
        int unsigned    rows;
        int unsigned    pick;
        cols          = usable(columns_reg);
        rows          = usable(rows_reg);
        pick          = $urandom_range(0, 99);
        req.op        = 2'($urandom);
        req.rect_x    = 12'($urandom);
        req.rect_y    = 12'($urandom);
        req.rect_w    = 12'($urandom);
        req.rect_h    = 12'($urandom);
        req.row_index = 5'($urandom);
        req.row_bits  = $urandom;
        if (pick < 38)
        begin
            req.op = tdm_pkg::OP_MARK;
            if ($urandom_range(0, 9) != 0)
            begin
                req.rect_x = 12'($urandom_range(0, cols * TILE_PX_W + 15));
                req.rect_y = 12'($urandom_range(0, rows * TILE_PX_H + 15));
                req.rect_w = 12'($urandom_range(0, 64));
                req.rect_h = 12'($urandom_range(0, 48));
            end
        end
        else if (pick < 93)
        begin
            req.op = (pick < 58) ? tdm_pkg::OP_MERGE : tdm_pkg::OP_RESTORE;
            if ($urandom_range(0, 7) != 0)
                req.row_index = 5'($urandom_range(0, rows - 1));
        end
        else if (pick < 97)
        begin
            req.op = tdm_pkg::OP_CLEAR;
        end
        return req;
    endfunction

    task automatic run_random(input int unsigned count);
        repeat (count) send_request(random_request(), 1'b0, NO_TILE);
    endtask

    function automatic plan_row_t plan(input logic [1:0] op, input int unsigned x,
                                       input int unsigned y, input int unsigned w,
                                       input int unsigned h, input int unsigned row,
                                       input logic [tdm_pkg::ROW_W-1:0] bits,
                                       input bit typed, input tdm_pkg::result_t want);
        plan_row_t p;
        p.req   = '{op: op, rect_x: 12'(x), rect_y: 12'(y), rect_w: 12'(w), rect_h: 12'(h),
                    row_index: 5'(row), row_bits: bits};
        p.typed = typed;
        p.want  = want;
        return p;
    endfunction

    // receiver: random stalls, plus one long hold-off when asked
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_request && !hold_finished)
            begin
                result_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_finished = 1'b1;
            end
            else
            begin
                result_ready <= ($urandom_range(0, 99) >= receiver_idle_pct);
            end
        end
    end

    // compare each taken result with the oldest expectation
    always @(posedge clk)
    begin
        tdm_pkg::result_t want;
        if (rst_n && result_valid && result_ready)
        begin
            if (awaited_results.size() == 0)
            begin
                report_mismatch($sformatf("unexpected result %p", result));
            end
            else
            begin
                want = awaited_results.pop_front();
                if (result.tile_valid !== want.tile_valid)
                    report_mismatch($sformatf("tile_valid %b, want %b",
                                              result.tile_valid, want.tile_valid));
                if (result.tile_x !== want.tile_x)
                    report_mismatch($sformatf("tile_x %0d, want %0d",
                                              result.tile_x, want.tile_x));
                if (result.tile_y !== want.tile_y)
                    report_mismatch($sformatf("tile_y %0d, want %0d",
                                              result.tile_y, want.tile_y));
                if (result.last !== want.last)
                    report_mismatch($sformatf("last %b, want %b", result.last, want.last));
            end
        end
    end

    initial
    begin
        #4000000;
        $display("tb failed");
        $finish;
    end

    initial
    begin
        columns_reg = tdm_pkg::COLUMNS_RESET;
        rows_reg    = tdm_pkg::ROWS_RESET;
        foreach (dirty_words[i])
            dirty_words[i] = '0;
        sender_idle_pct   = 31;
        receiver_idle_pct = 72;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part, 20 columns and 12 rows after reset
        opening_plan.push_back(plan(tdm_pkg::OP_RESTORE, 0, 0, 0, 0, 0, '0, 1'b1, NO_TILE));
        opening_plan.push_back(plan(tdm_pkg::OP_MARK, 0, 0, 1, 1, 0, '0, 1'b1, NO_TILE));
        opening_plan.push_back(plan(tdm_pkg::OP_RESTORE, 0, 0, 0, 0, 0, '0, 1'b1,
                                    '{tile_valid: 1'b1, tile_x: '0, tile_y: '0, last: 1'b1}));
        // empty rectangles and spans past the map
        opening_plan.push_back(plan(tdm_pkg::OP_MARK, 0, 0, 0, 4095, 0, '0, 1'b1, NO_TILE));
        opening_plan.push_back(plan(tdm_pkg::OP_MARK, 0, 0, 4095, 0, 0, '0, 1'b1, NO_TILE));
        opening_plan.push_back(plan(tdm_pkg::OP_MARK, 4095, 4095, 4095, 4095, 31, '1, 1'b1,
                                    NO_TILE));
        opening_plan.push_back(plan(tdm_pkg::OP_MARK, 320, 0, 16, 16, 0, '0, 1'b1, NO_TILE));
        opening_plan.push_back(plan(tdm_pkg::OP_RESTORE, 0, 0, 0, 0, 0, '0, 1'b1, NO_TILE));
        opening_plan.push_back(plan(tdm_pkg::OP_MARK, 300, 180, 4095, 4095, 0, '0, 1'b0,
                                    NO_TILE));
        opening_plan.push_back(plan(tdm_pkg::OP_RESTORE, 0, 0, 0, 0, 11, '0, 1'b0, NO_TILE));
        // merge drops bits past the columns in use and rows past the map
        opening_plan.push_back(plan(tdm_pkg::OP_MERGE, 0, 0, 0, 0, 3, '1, 1'b1, NO_TILE));
        opening_plan.push_back(plan(tdm_pkg::OP_RESTORE, 0, 0, 0, 0, 3, '0, 1'b0, NO_TILE));
        opening_plan.push_back(plan(tdm_pkg::OP_MERGE, 0, 0, 0, 0, 31, '1, 1'b1, NO_TILE));
        opening_plan.push_back(plan(tdm_pkg::OP_RESTORE, 0, 0, 0, 0, 31, '0, 1'b1, NO_TILE));
        opening_plan.push_back(plan(tdm_pkg::OP_MERGE, 0, 0, 0, 0, 12, '1, 1'b1, NO_TILE));
        opening_plan.push_back(plan(tdm_pkg::OP_RESTORE, 0, 0, 0, 0, 12, '0, 1'b1, NO_TILE));
        // whole map, then clear
        opening_plan.push_back(plan(tdm_pkg::OP_MARK, 0, 0, 4095, 4095, 0, '0, 1'b1, NO_TILE));
        opening_plan.push_back(plan(tdm_pkg::OP_RESTORE, 0, 0, 0, 0, 0, '0, 1'b0, NO_TILE));
        opening_plan.push_back(plan(tdm_pkg::OP_RESTORE, 0, 0, 0, 0, 0, '0, 1'b1, NO_TILE));
        opening_plan.push_back(plan(tdm_pkg::OP_CLEAR, 4095, 4095, 4095, 4095, 31, '1, 1'b1,
                                    NO_TILE));
        opening_plan.push_back(plan(tdm_pkg::OP_RESTORE, 0, 0, 0, 0, 5, '0, 1'b1, NO_TILE));
        opening_plan.push_back(plan(tdm_pkg::OP_MERGE, 0, 0, 0, 0, 0, 32'hAAAA_AAAA, 1'b1,
                                    NO_TILE));
        opening_plan.push_back(plan(tdm_pkg::OP_MERGE, 0, 0, 0, 0, 0, 32'h5555_5555, 1'b1,
                                    NO_TILE));
        opening_plan.push_back(plan(tdm_pkg::OP_RESTORE, 0, 0, 0, 0, 0, '0, 1'b0, NO_TILE));
        // a small rectangle straddling a tile corner
        opening_plan.push_back(plan(tdm_pkg::OP_MARK, 15, 15, 2, 2, 0, '0, 1'b1, NO_TILE));
        opening_plan.push_back(plan(tdm_pkg::OP_RESTORE, 0, 0, 0, 0, 1, '0, 1'b0, NO_TILE));
        foreach (opening_plan[k])
            send_request(opening_plan[k].req, opening_plan[k].typed, opening_plan[k].want);
        wait_idle();

        // largest map
        resize_map(6'd32, 6'd32);
        run_random(30);
        wait_idle();

        // swap idling, and let the receiver hold off so the block backs up
        sender_idle_pct   = 72;
        receiver_idle_pct = 31;
        hold_request      = 1'b1;
        run_random(12);
        wait_idle();

        resize_map(6'd1, 6'd1);
        run_random(10);
        wait_idle();

        // out-of-range register values
        resize_map(6'd63, 6'd0);
        run_random(10);
        wait_idle();

        // no idling on either side
        sender_idle_pct   = 0;
        receiver_idle_pct = 0;
        resize_map(6'd7, 6'd25);
        run_random(20);
        wait_idle();

        resize_map(6'd0, 6'd63);
        run_random(10);
        wait_idle();

        if (mismatch_count == 0 && awaited_results.size() == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

endmodule
